// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default clk_i / rst_ni pair
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ===== rtl/rgb2hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Types and constants shared by the RGB to HSV converter modules.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  // Field widths
  localparam int ChanW = 8;
  localparam int HueW  = 12;
  // Quotient width of both dividers (hue offset reaches 600)
  localparam int QuoW  = 10;

  // Hue constants, tenths of a degree
  localparam int HueSector = 600;
  localparam int HueGreen  = 1200;
  localparam int HueBlue   = 2400;
  localparam int HueFull   = 3600;
  localparam int FullScale = 255;

  // Default build settings
  localparam int DefaultQueueDepth = 4;
  localparam int DefaultDivSteps   = 2;

  // Which channel holds the maximum
  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  // Input word
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // Output word
  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  // Classified pixel, front to back
  typedef struct packed {
    sector_e          sector;
    logic             neg;
    logic [ChanW-1:0] mag;
    logic [ChanW-1:0] delta;
    logic [ChanW-1:0] vmax;
  } cls_t;

  // Sideband carried alongside the divider pipeline
  typedef struct packed {
    sector_e          sector;
    logic             neg;
    logic             gray;
    logic [ChanW-1:0] vmax;
  } side_t;

endpackage

// ===== rtl/rgb2hsv_front.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_front
// Accepts pixels, finds max/min, sector and signed hue numerator; one
// register stage.
// ----------------------------------------------------------------------------
module rgb2hsv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgb2hsv_pkg::pixel_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgb2hsv_pkg::cls_t   out_cls_o
);

  logic              vld_q;
  rgb2hsv_pkg::cls_t cls_q, cls_d;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_cls_o   = cls_q;

  // Classify: max (red wins ties, then green), min, delta, hue numerator
  always_comb begin
    logic [rgb2hsv_pkg::ChanW-1:0] r, g, b, mn;
    logic [rgb2hsv_pkg::ChanW:0]   diff, ndiff;
    r = in_word_i.red;
    g = in_word_i.green;
    b = in_word_i.blue;
    cls_d = '0;
    diff  = '0;
    priority if (r >= g && r >= b) begin
      cls_d.sector = rgb2hsv_pkg::SecRed;
      cls_d.vmax   = r;
      diff         = {1'b0, g} - {1'b0, b};
    end else if (g >= b) begin
      cls_d.sector = rgb2hsv_pkg::SecGreen;
      cls_d.vmax   = g;
      diff         = {1'b0, b} - {1'b0, r};
    end else begin
      cls_d.sector = rgb2hsv_pkg::SecBlue;
      cls_d.vmax   = b;
      diff         = {1'b0, r} - {1'b0, g};
    end
    priority if (r <= g && r <= b) begin
      mn = r;
    end else if (g <= b) begin
      mn = g;
    end else begin
      mn = b;
    end
    ndiff       = ~diff + 1'b1;
    cls_d.neg   = diff[rgb2hsv_pkg::ChanW];
    cls_d.mag   = cls_d.neg ? ndiff[rgb2hsv_pkg::ChanW-1:0] : diff[rgb2hsv_pkg::ChanW-1:0];
    cls_d.delta = cls_d.vmax - mn;
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cls_q <= cls_d;
    end
  end

endmodule

// ===== rtl/rgb2hsv_fifo.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb2hsv_fifo #(
  parameter int Depth = rgb2hsv_pkg::DefaultQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rgb2hsv_pkg::cls_t in_cls_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rgb2hsv_pkg::cls_t out_cls_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  rgb2hsv_pkg::cls_t mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_cls_o   = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cls_i;
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count above depth")
  `ASSERT_CLK(a_cnt_up, push && !pop |=> cnt_q == $past(cnt_q) + 1'b1, "count missed a push")
  `ASSERT_CLK(a_ptr_gap, cnt_q == '0 |-> wr_ptr_q == rd_ptr_q, "empty queue with pointer gap")

endmodule

// ===== rtl/rgb2hsv_div.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_div
// Pipelined restoring divider: a few quotient bits per stage, one word
// enters per enabled cycle.
// ----------------------------------------------------------------------------
module rgb2hsv_div #(
  parameter int QuoW  = rgb2hsv_pkg::QuoW,
  parameter int DenW  = rgb2hsv_pkg::ChanW,
  parameter int Steps = rgb2hsv_pkg::DefaultDivSteps
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [QuoW+DenW-1:0]   num_i,
  input  logic [DenW-1:0]        den_i,
  output logic [QuoW-1:0]        quo_o,
  output logic [DenW-1:0]        rem_o
);

  localparam int Stages = (QuoW + Steps - 1) / Steps;

  // Per stage: partial remainder, numerator bits shifting into quotient
  logic [DenW-1:0] rem_q [Stages];
  logic [QuoW-1:0] acc_q [Stages];
  logic [DenW-1:0] den_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [DenW-1:0] rem_in, rem_nx;
    logic [QuoW-1:0] acc_in, acc_nx;
    logic [DenW-1:0] den_in;

    // Stage inputs: the top numerator bits start the remainder
    if (s == 0) begin : g_first
      assign rem_in = num_i[QuoW+DenW-1:QuoW];
      assign acc_in = num_i[QuoW-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign acc_in = acc_q[s-1];
      assign den_in = den_q[s-1];
    end

    // Shift-subtract steps of this stage
    always_comb begin
      logic [DenW:0] t;
      logic          qb;
      t      = '0;
      qb     = 1'b0;
      rem_nx = rem_in;
      acc_nx = acc_in;
      for (int j = 0; j < Steps; j++) begin
        if (s * Steps + j < QuoW) begin
          t  = {rem_nx, acc_nx[QuoW-1]};
          qb = (t >= {1'b0, den_in});
          if (qb) begin
            t = t - {1'b0, den_in};
          end
          rem_nx = t[DenW-1:0];
          acc_nx = {acc_nx[QuoW-2:0], qb};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_nx;
        acc_q[s] <= acc_nx;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = acc_q[Stages-1];
  assign rem_o = rem_q[Stages-1];

endmodule

// ===== rtl/rgb2hsv_back.sv =====
// ----------------------------------------------------------------------------
// rgb2hsv_back
// Runs hue and saturation divisions side by side and assembles the HSV
// word in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb2hsv_back #(
  parameter int DivSteps = rgb2hsv_pkg::DefaultDivSteps
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rgb2hsv_pkg::cls_t in_cls_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rgb2hsv_pkg::hsv_t out_word_o
);

  localparam int QuoW   = rgb2hsv_pkg::QuoW;
  localparam int ChanW  = rgb2hsv_pkg::ChanW;
  localparam int HueW   = rgb2hsv_pkg::HueW;
  localparam int NumW   = QuoW + ChanW;
  localparam int Stages = (QuoW + DivSteps - 1) / DivSteps;

  logic               adv;
  logic               vld_q [Stages];
  rgb2hsv_pkg::side_t side_q [Stages];
  rgb2hsv_pkg::side_t side_in, side_out;
  logic [NumW-1:0]    hue_num, sat_num;
  logic [QuoW-1:0]    hue_quo, sat_quo;
  logic [ChanW-1:0]   hue_rem, sat_rem;
  logic               sat_chk;
  logic               out_vld_q;
  rgb2hsv_pkg::hsv_t  out_word_q, out_word_d;

  // Whole pipeline moves when the output register is free
  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

  // Constant-scaled numerators
  assign hue_num = NumW'(in_cls_i.mag) * NumW'(rgb2hsv_pkg::HueSector);
  assign sat_num = NumW'(in_cls_i.delta) * NumW'(rgb2hsv_pkg::FullScale);

  assign side_in.sector = in_cls_i.sector;
  assign side_in.neg    = in_cls_i.neg;
  assign side_in.gray   = (in_cls_i.delta == '0);
  assign side_in.vmax   = in_cls_i.vmax;

  rgb2hsv_div #(
    .QuoW  (QuoW),
    .DenW  (ChanW),
    .Steps (DivSteps)
  ) u_hue_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (hue_num),
    .den_i (in_cls_i.delta),
    .quo_o (hue_quo),
    .rem_o (hue_rem)
  );

  rgb2hsv_div #(
    .QuoW  (QuoW),
    .DenW  (ChanW),
    .Steps (DivSteps)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sat_num),
    .den_i (in_cls_i.vmax),
    .quo_o (sat_quo),
    .rem_o (sat_rem)
  );

  // Valid line matching the divider depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        vld_q[s] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < Stages; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      out_vld_q <= vld_q[Stages-1];
    end
  end

  // Sideband line and output word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int s = 1; s < Stages; s++) begin
        side_q[s] <= side_q[s-1];
      end
      out_word_q <= out_word_d;
    end
  end

  assign side_out = side_q[Stages-1];

  // Saturation division is meaningful for a valid, non-black word
  assign sat_chk = vld_q[Stages-1] && (side_out.vmax != '0);

  // Hue: sector base plus or minus the floored offset
  always_comb begin
    logic [HueW-1:0] xmag, base;
    xmag = HueW'(hue_quo) + HueW'(side_out.neg && (hue_rem != '0));
    unique case (side_out.sector)
      rgb2hsv_pkg::SecRed:   base = side_out.neg ? HueW'(rgb2hsv_pkg::HueFull) : '0;
      rgb2hsv_pkg::SecGreen: base = HueW'(rgb2hsv_pkg::HueGreen);
      rgb2hsv_pkg::SecBlue:  base = HueW'(rgb2hsv_pkg::HueBlue);
      default:               base = '0;
    endcase
    out_word_d.hue        = side_out.gray ? '0 :
                            (side_out.neg ? base - xmag : base + xmag);
    out_word_d.saturation = (side_out.vmax == '0) ? '0 : sat_quo[ChanW-1:0];
    out_word_d.brightness = side_out.vmax;
  end

  `ASSERT_CLK(a_hue_range, out_vld_q |-> out_word_q.hue < HueW'(rgb2hsv_pkg::HueFull), "hue out of range")
  `ASSERT_CLK(a_black, out_vld_q && out_word_q.brightness == '0 |-> out_word_q.saturation == '0 && out_word_q.hue == '0, "black pixel not zero")
  `ASSERT_CLK(a_drain, vld_q[Stages-1] && adv |=> out_vld_q, "finished word lost")
  `ASSERT_CLK(a_sat_quo, sat_chk |-> sat_quo[QuoW-1:ChanW] == '0, "saturation above full scale")
  `ASSERT_CLK(a_sat_rem, sat_chk |-> sat_rem < side_out.vmax, "saturation remainder too large")

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts 8-bit RGB pixels to hue (tenths of a degree), saturation and
// value.
// ----------------------------------------------------------------------------
//  channel | signals                            | word
//  --------+------------------------------------+---------------------------
//  pixel   | in_valid_i, in_ready_o, in_word_i  | red, green, blue
//  hsv     | out_valid_o, out_ready_i, out_word_o | hue, saturation, brightness
//
// One pixel per clock sustained while the output is not stalled. Pipeline:
// front register, queue, divider stages, output register.
// The two pipelined dividers (quotient bits per stage = DivSteps) set depth.
// Reset clears only valid flags, queue pointers and count.
// An output stall freezes the back; the queue absorbs QueueDepth words
// before the front stalls.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
  parameter int QueueDepth = rgb2hsv_pkg::DefaultQueueDepth,
  parameter int DivSteps   = rgb2hsv_pkg::DefaultDivSteps
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgb2hsv_pkg::pixel_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgb2hsv_pkg::hsv_t   out_word_o
);

  logic              fr_valid, fr_ready;
  rgb2hsv_pkg::cls_t fr_cls;
  logic              q_valid, q_ready;
  rgb2hsv_pkg::cls_t q_cls;

  // Front: classify
  rgb2hsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_cls_o   (fr_cls)
  );

  // Decoupling queue
  rgb2hsv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_cls_i    (fr_cls),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cls_o   (q_cls)
  );

  // Back: divide and assemble
  rgb2hsv_back #(
    .DivSteps (DivSteps)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_cls_i    (q_cls),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - RGB to HSV converter bench
// Streams pixel words through rgb_to_hsv_converter with random idling on
// both channels. A directed table covers the extreme colors, gray, black
// and ties for the maximum, then random pixels follow. Every hsv word is
// checked field by field against an in-order queue of predicted words.
// ----------------------------------------------------------------------------
module tb;

  localparam int ChanW      = rgb2hsv_pkg::ChanW;
  localparam int HueW       = rgb2hsv_pkg::HueW;
  localparam int NumRandom  = 2000;
  localparam int PhaseLen   = 150;
  localparam int DrainCyc   = 40;
  localparam int CycleLimit = 400000;
  localparam int NumDir     = 20;

  // Directed row: pixel, and the hsv word when it is obvious at a glance
  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    bit               typed;
    logic [HueW-1:0]  h;
    logic [ChanW-1:0] s;
    logic [ChanW-1:0] v;
  } dir_row_t;

  dir_row_t dir_table [NumDir] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 12'd0,    8'd0,   8'd0  },  // black
    '{8'd255, 8'd255, 8'd255, 1'b1, 12'd0,    8'd0,   8'd255},  // white
    '{8'd128, 8'd128, 8'd128, 1'b1, 12'd0,    8'd0,   8'd128},  // mid gray
    '{8'd255, 8'd0,   8'd0,   1'b1, 12'd0,    8'd255, 8'd255},  // red
    '{8'd0,   8'd255, 8'd0,   1'b1, 12'd1200, 8'd255, 8'd255},  // green
    '{8'd0,   8'd0,   8'd255, 1'b1, 12'd2400, 8'd255, 8'd255},  // blue
    '{8'd255, 8'd255, 8'd0,   1'b1, 12'd600,  8'd255, 8'd255},  // yellow, red wins tie
    '{8'd0,   8'd255, 8'd255, 1'b1, 12'd1800, 8'd255, 8'd255},  // cyan, green wins tie
    '{8'd255, 8'd0,   8'd255, 1'b1, 12'd3000, 8'd255, 8'd255},  // magenta, hue wraps
    '{8'd1,   8'd0,   8'd0,   1'b1, 12'd0,    8'd255, 8'd1  },  // tiny red
    '{8'd0,   8'd0,   8'd1,   1'b1, 12'd2400, 8'd255, 8'd1  },  // tiny blue
    '{8'd1,   8'd1,   8'd0,   1'b1, 12'd600,  8'd255, 8'd1  },  // tiny tie r/g
    '{8'd0,   8'd1,   8'd1,   1'b1, 12'd1800, 8'd255, 8'd1  },  // tiny tie g/b
    '{8'd255, 8'd255, 8'd254, 1'b1, 12'd600,  8'd1,   8'd255},  // near gray
    '{8'd255, 8'd0,   8'd1,   1'b0, 12'd0,    8'd0,   8'd0  },  // just below wrap
    '{8'd254, 8'd255, 8'd0,   1'b0, 12'd0,    8'd0,   8'd0  },
    '{8'd200, 8'd100, 8'd150, 1'b0, 12'd0,    8'd0,   8'd0  },
    '{8'd10,  8'd20,  8'd30,  1'b0, 12'd0,    8'd0,   8'd0  },
    '{8'haa,  8'h55,  8'hff,  1'b0, 12'd0,    8'd0,   8'd0  },
    '{8'h55,  8'haa,  8'h00,  1'b0, 12'd0,    8'd0,   8'd0  }
  };

  logic                clk_i     = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                out_ready = 1'b0;
  rgb2hsv_pkg::pixel_t in_word   = '0;
  logic                in_ready;
  logic                out_valid;
  rgb2hsv_pkg::hsv_t   out_word;

  rgb2hsv_pkg::pixel_t pixel_list  [$];
  bit                  typed_list  [$];
  rgb2hsv_pkg::hsv_t   typed_hsv   [$];
  rgb2hsv_pkg::hsv_t   pending_hsv [$];
  rgb2hsv_pkg::pixel_t pending_px  [$];

  int     num_pixels = 0;
  int     accepted   = 0;
  int     num_errors = 0;
  int     cycles     = 0;
  bit     built      = 1'b0;

  rgb_to_hsv_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always #5 clk_i = ~clk_i;

  // Integer HSV of one pixel
  function automatic rgb2hsv_pkg::hsv_t predict_hsv(rgb2hsv_pkg::pixel_t px);
    int                   r, g, b, mx, mn, dl, n, off, h;
    rgb2hsv_pkg::sector_e sec;
    rgb2hsv_pkg::hsv_t    res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    h = 0;
    if (dl != 0) begin
      if (mx == r) begin
        sec = rgb2hsv_pkg::SecRed;
        n = g - b;
      end else if (mx == g) begin
        sec = rgb2hsv_pkg::SecGreen;
        n = b - r;
      end else begin
        sec = rgb2hsv_pkg::SecBlue;
        n = r - g;
      end
      // floor division toward minus infinity
      if (n >= 0) off = (rgb2hsv_pkg::HueSector * n) / dl;
      else off = -((rgb2hsv_pkg::HueSector * (-n) + dl - 1) / dl);
      case (sec)
        rgb2hsv_pkg::SecRed:   h = (off < 0) ? off + rgb2hsv_pkg::HueFull : off;
        rgb2hsv_pkg::SecGreen: h = rgb2hsv_pkg::HueGreen + off;
        default:               h = rgb2hsv_pkg::HueBlue + off;
      endcase
    end
    res.hue        = h[HueW-1:0];
    res.saturation = (mx != 0) ? ChanW'((rgb2hsv_pkg::FullScale * dl) / mx) : '0;
    res.brightness = mx[ChanW-1:0];
    return res;
  endfunction

  // Random pixel: mostly uniform, with gray, ties and dim values mixed in
  function automatic rgb2hsv_pkg::pixel_t random_pixel();
    rgb2hsv_pkg::pixel_t px;
    int                  pick;
    pick = int'($urandom_range(99));
    px.red   = ChanW'($urandom_range(255));
    px.green = ChanW'($urandom_range(255));
    px.blue  = ChanW'($urandom_range(255));
    if (pick < 10) begin
      px.green = px.red;
      px.blue  = px.red;
    end else if (pick < 17) begin
      px.green = px.red;
    end else if (pick < 24) begin
      px.blue = px.green;
    end else if (pick < 30) begin
      px.blue = px.red;
    end else if (pick < 40) begin
      px.red   = ChanW'($urandom_range(3));
      px.green = ChanW'($urandom_range(3));
      px.blue  = ChanW'($urandom_range(3));
    end
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch %s", msg);
    num_errors++;
  endtask

  // Build the stimulus list: directed table, then random pixels
  initial begin
    rgb2hsv_pkg::pixel_t px;
    for (int i = 0; i < NumDir; i++) begin
      px.red   = dir_table[i].r;
      px.green = dir_table[i].g;
      px.blue  = dir_table[i].b;
      pixel_list.push_back(px);
      typed_list.push_back(dir_table[i].typed);
      typed_hsv.push_back({dir_table[i].h, dir_table[i].s, dir_table[i].v});
    end
    for (int i = 0; i < NumRandom; i++) begin
      pixel_list.push_back(random_pixel());
      typed_list.push_back(1'b0);
      typed_hsv.push_back('0);
    end
    num_pixels = pixel_list.size();
    built = 1'b1;
  end

  // Drive pixels, accept hsv words, check in order
  always @(posedge clk_i) begin : drive_p
    int                  phase;
    int                  send_idle;
    int                  recv_idle;
    int                  nxt;
    bit                  took;
    rgb2hsv_pkg::pixel_t px;
    rgb2hsv_pkg::hsv_t   want;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // idling phases rotate through the run
      phase = (accepted / PhaseLen) % 4;
      case (phase)
        0:       begin send_idle = 0;  recv_idle = 0;  end
        1:       begin send_idle = 83; recv_idle = 0;  end
        2:       begin send_idle = 0;  recv_idle = 83; end
        default: begin send_idle = 14; recv_idle = 14; end
      endcase

      // result side
      if (out_valid && out_ready) begin
        if (pending_hsv.size() == 0) begin
          report_mismatch($sformatf("unexpected hsv word %h", out_word));
        end else begin
          want = pending_hsv.pop_front();
          px   = pending_px.pop_front();
          if (out_word.hue != want.hue)
            report_mismatch($sformatf("hue: got %0d want %0d (rgb %0d,%0d,%0d)",
                                      out_word.hue, want.hue,
                                      px.red, px.green, px.blue));
          if (out_word.saturation != want.saturation)
            report_mismatch($sformatf("saturation: got %0d want %0d (rgb %0d,%0d,%0d)",
                                      out_word.saturation, want.saturation,
                                      px.red, px.green, px.blue));
          if (out_word.brightness != want.brightness)
            report_mismatch($sformatf("brightness: got %0d want %0d (rgb %0d,%0d,%0d)",
                                      out_word.brightness, want.brightness,
                                      px.red, px.green, px.blue));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);

      // pixel side
      took = in_valid && in_ready;
      nxt  = accepted;
      if (took) begin
        pending_hsv.push_back(typed_list[accepted] ? typed_hsv[accepted]
                                                   : predict_hsv(in_word));
        pending_px.push_back(in_word);
        nxt = accepted + 1;
        accepted <= nxt;
      end
      if (!in_valid || took) begin
        if (built && nxt < num_pixels && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_word  <= pixel_list[nxt];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Reset, then wait for all words to come back
  initial begin
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    while (!(built && accepted == num_pixels && pending_hsv.size() == 0))
      @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (num_errors == 0 && pending_hsv.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
